@@ hdl/psh_pkg.sv @@
// Package for the polynomial string hash core.
// Holds field widths, the hash multiplier, the config reset value,
// the sequencer state type and the remainder-unit control and status structs.
package psh_pkg;

    localparam int CHAR_W  = 8;
    localparam int HASH_W  = 31;
    localparam int ACC_W   = 32;
    localparam int CNT_W   = $clog2(ACC_W);

    localparam logic [ACC_W-1:0]  HASH_MULT        = ACC_W'(37);
    localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = HASH_W'(1000000007);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic load;   // capture magnitude and sign, clear remainder
        logic step;   // one shift-subtract iteration
        logic fix;    // steer subtractor to modulus - remainder
    } rem_ctrl_t;

    typedef struct packed {
        logic last_step;  // current step is the final iteration
    } rem_stat_t;

endpackage

@@ hdl/psh_rem_unit.sv @@
// Iterative remainder unit: restoring shift-subtract, one bit per cycle.
// One shared subtractor serves both the iterations and the sign fix-up.
// Depends on psh_pkg.
module psh_rem_unit
    import psh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rem_ctrl_t         ctrl,
    input  logic [ACC_W-1:0]  load_mag,
    input  logic              load_neg,
    input  logic [HASH_W-1:0] modulus,
    output rem_stat_t         stat,
    output logic [HASH_W-1:0] result
);

    logic [ACC_W-1:0] dvd_reg, dvd_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [ACC_W-1:0] shifted;
    logic [ACC_W-1:0] sub_a, sub_b;
    logic [ACC_W:0]   diff;
    logic             borrow;

    assign shifted = {rem_reg[ACC_W-2:0], dvd_reg[ACC_W-1]};

    // Shared subtractor: iterate with shifted - modulus, fix with modulus - remainder.
    always_comb begin
        if (ctrl.fix) begin
            sub_a = {1'b0, modulus};
            sub_b = rem_reg;
        end else begin
            sub_a = shifted;
            sub_b = {1'b0, modulus};
        end
    end

    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[ACC_W];

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            dvd_next = load_mag;
            rem_next = '0;
            neg_next = load_neg;
            cnt_next = '0;
        end else if (ctrl.step) begin
            dvd_next = {dvd_reg[ACC_W-2:0], 1'b0};
            rem_next = borrow ? shifted : diff[ACC_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign stat.last_step = (cnt_reg == CNT_W'(ACC_W - 1));

    // Negative dividend with nonzero remainder: take modulus - remainder.
    assign result = (neg_reg && (rem_reg != '0)) ? diff[HASH_W-1:0] : rem_reg[HASH_W-1:0];

endmodule

@@ hdl/polynomial_string_hash_mod_core.sv @@
// Top level of the polynomial string hash core (multiplier 37, reduced mod table size).
// Instantiates psh_rem_unit; depends on psh_pkg.
//
// Usage:
//   Input stream (s_*): one key character per transaction, s_tdata = char_code
//   (signed 8 bit), s_tlast marks the final character of the key.
//   Output stream (m_*): one transaction per key, m_tdata = hash_value in
//   0 .. table_size-1, zero-padded to 32 bits.
//   Config: cfg_wr_en/cfg_wr_data write table_size; write only while idle.
//
// Timing:
//   A non-final character is folded into the accumulator in the cycle it is
//   accepted (acc = 37*acc + char), so characters stream at one per cycle while idle.
//   A final character starts a 32-iteration restoring remainder in the shared
//   subtractor, then a fix-up step; s_tready stays low until the result is
//   loaded into the output register.
//   The 32-bit width of the accumulator sets the iteration count.
//
// Reset and stall:
//   Reset clears the accumulator, sets table_size to 1000000007, empties the
//   output register. The output register holds the result while m_tready is
//   low; new characters are still taken meanwhile, and a second finished key
//   waits in the fix-up state until the output register frees up.
module polynomial_string_hash_mod_core
    import psh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] hash_value, [31] zero
    // configuration
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data // table_size
);

    state_t state_reg, state_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HASH_W-1:0] table_size_reg;
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] m_data_reg, m_data_next;

    rem_ctrl_t         rem_ctrl;
    rem_stat_t         rem_stat;
    logic [HASH_W-1:0] rem_result;

    logic              in_xact;
    logic              out_free;
    logic              out_load;
    logic [ACC_W-1:0]  acc_upd;
    logic [ACC_W-1:0]  acc_mag;

    // Accumulator update: wrap to 32 bits, character sign-extended.
    assign acc_upd = ACC_W'(acc_reg * HASH_MULT)
                   + {{(ACC_W-CHAR_W){s_tdata[CHAR_W-1]}}, s_tdata};
    assign acc_mag = acc_upd[ACC_W-1] ? (~acc_upd + ACC_W'(1)) : acc_upd;

    assign in_xact  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xact && s_tlast) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_stat.last_step) state_next = ST_FIX;
            end
            ST_FIX: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output / control logic
    always_comb begin
        s_tready      = 1'b0;
        rem_ctrl      = '0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = aresetn;
                rem_ctrl.load = in_xact && s_tlast;
            end
            ST_DIV: begin
                rem_ctrl.step = 1'b1;
            end
            ST_FIX: begin
                rem_ctrl.fix = 1'b1;
                out_load     = out_free;
            end
            default: ;
        endcase
    end

    // Fold the character in; clear after the final one of a key.
    always_comb begin
        acc_next = acc_reg;
        if (in_xact) begin
            acc_next = s_tlast ? '0 : acc_upd;
        end
    end

    // Output register: load the fixed-up remainder, drop on a taken transaction.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (out_load) begin
            m_valid_next = 1'b1;
            // zero table size is out of range; report zero
            m_data_next  = (table_size_reg == '0) ? '0 : rem_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) table_size_reg <= cfg_wr_data;
        end
        m_data_reg <= m_data_next;
    end

    psh_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rem_ctrl),
        .load_mag (acc_mag),
        .load_neg (acc_upd[ACC_W-1]),
        .modulus  (table_size_reg),
        .stat     (rem_stat),
        .result   (rem_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule
